### rtl/core/kvp_pkg.sv
// Package for the key-value text stream parser: phase and event codes, character
// constants, the parser state and event list types, and the per-byte step functions.
// Depends on nothing; every module of the parser imports it.
package kvp_pkg;

  localparam logic [5:0] MAX_NESTING = 6'd32;
  localparam logic [5:0] LIMIT_RST   = 6'd32;
  localparam int unsigned MAX_EV     = 6;
  localparam int unsigned EV_CNT_W   = $clog2(MAX_EV + 1);

  // Parser phases.
  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_SKIP    = 3'd1;
  localparam logic [2:0] PH_SLASH   = 3'd2;
  localparam logic [2:0] PH_COMMENT = 3'd3;
  localparam logic [2:0] PH_BARE    = 3'd4;
  localparam logic [2:0] PH_QUOTED  = 3'd5;
  localparam logic [2:0] PH_ESCAPE  = 3'd6;

  // Event kinds.
  localparam logic [2:0] EV_BYTE   = 3'd0;
  localparam logic [2:0] EV_END    = 3'd1;
  localparam logic [2:0] EV_OPEN   = 3'd2;
  localparam logic [2:0] EV_CLOSE  = 3'd3;
  localparam logic [2:0] EV_ACCEPT = 3'd4;
  localparam logic [2:0] EV_ERROR  = 3'd5;

  // Characters.
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] BOM0      = 8'hEF;
  localparam logic [7:0] BOM1      = 8'hBB;
  localparam logic [7:0] BOM2      = 8'hBF;

  typedef struct packed {
    logic [2:0] phase;
    logic       resume;     // 0 expect a name, 1 expect a value
    logic       role;
    logic [5:0] open_cnt;
    logic [1:0] held;       // byte-order mark bytes matched so far
    logic       failed;
  } pst_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       role;
    logic [5:0] level;
  } ev_t;

  typedef struct packed {
    ev_t [MAX_EV-1:0]    ev;
    logic [EV_CNT_W-1:0] cnt;
  } evl_t;

  typedef struct packed {
    pst_t st;
    evl_t evl;
  } ctx_t;

  localparam pst_t PST_RESET = '{phase: PH_START, resume: 1'b0, role: 1'b0,
                                 open_cnt: 6'd0, held: 2'd0, failed: 1'b0};

  function automatic logic [7:0] mark_byte(input logic [1:0] k);
    logic [7:0] m;
    case (k)
      2'd0:    m = BOM0;
      2'd1:    m = BOM1;
      default: m = BOM2;
    endcase
    return m;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic ends_bare(input logic [7:0] b);
    return is_blank(b) || (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_QUOTE);
  endfunction

  // Appends an event if the list has room; level is the current open block count.
  function automatic ctx_t ev_push(input ctx_t c, input logic [2:0] kind,
                                   input logic [7:0] data, input logic role);
    ctx_t r;
    r = c;
    if (r.evl.cnt < EV_CNT_W'(MAX_EV)) begin
      r.evl.ev[r.evl.cnt] = '{kind: kind, data: data, role: role, level: r.st.open_cnt};
      r.evl.cnt = r.evl.cnt + EV_CNT_W'(1);
    end
    return r;
  endfunction

  function automatic ctx_t fail(input ctx_t c);
    ctx_t r;
    r = ev_push(c, EV_ERROR, 8'h00, 1'b0);
    r.st.failed = 1'b1;
    return r;
  endfunction

  function automatic logic entry_ok(input ctx_t c, input logic [5:0] limit);
    logic [5:0] eff;
    eff = (limit > MAX_NESTING) ? MAX_NESTING : limit;
    return c.st.open_cnt < eff;
  endfunction

  function automatic ctx_t finish_token(input ctx_t c);
    ctx_t r;
    r = ev_push(c, EV_END, 8'h00, c.st.role);
    r.st.resume = ~c.st.role;
    r.st.phase  = PH_SKIP;
    return r;
  endfunction

  function automatic ctx_t begin_bare(input ctx_t c, input logic [7:0] b,
                                      input logic [5:0] limit);
    ctx_t r;
    r = c;
    if (!r.st.resume && !entry_ok(r, limit)) begin
      r = fail(r);
    end else begin
      r.st.role  = r.st.resume;
      r = ev_push(r, EV_BYTE, b, r.st.role);
      r.st.phase = PH_BARE;
    end
    return r;
  endfunction

  function automatic ctx_t start_token(input ctx_t c, input logic [7:0] b);
    ctx_t r;
    r = c;
    r.st.role = r.st.resume;
    if (b == CH_QUOTE) begin
      r.st.phase = PH_QUOTED;
    end else begin
      r = ev_push(r, EV_BYTE, b, r.st.role);
      r.st.phase = PH_BARE;
    end
    return r;
  endfunction

  // Handles one byte while skipping whitespace between tokens.
  function automatic ctx_t skip_byte(input ctx_t c, input logic [7:0] b,
                                     input logic [5:0] limit);
    ctx_t r;
    r = c;
    if (is_blank(b)) begin
      r = c;
    end else if (b == CH_SLASH) begin
      r.st.phase = PH_SLASH;
    end else if (!r.st.resume) begin
      if (b == CH_RBRACE) begin
        if (r.st.open_cnt == 6'd0) begin
          r = fail(r);
        end else begin
          r.st.open_cnt = r.st.open_cnt - 6'd1;
          r = ev_push(r, EV_CLOSE, 8'h00, 1'b0);
        end
      end else if (!entry_ok(r, limit)) begin
        r = fail(r);
      end else if (b == CH_LBRACE) begin
        r = fail(r);
      end else begin
        r = start_token(r, b);
      end
    end else begin
      if (b == CH_LBRACE) begin
        r.st.open_cnt = r.st.open_cnt + 6'd1;
        r = ev_push(r, EV_OPEN, 8'h00, 1'b0);
        r.st.resume = 1'b0;
      end else if (b == CH_RBRACE) begin
        r = fail(r);
      end else begin
        r = start_token(r, b);
      end
    end
    return r;
  endfunction

  // Ordinary handling of one text byte after the byte-order mark check.
  function automatic ctx_t feed(input ctx_t c, input logic [7:0] b,
                                input logic [5:0] limit);
    ctx_t r;
    logic go_bare;
    logic go_skip;
    r = c;
    go_bare = 1'b0;
    go_skip = 1'b0;
    if (!r.st.failed) begin
      unique case (r.st.phase)
        PH_SLASH: begin
          if (b == CH_SLASH) begin
            r.st.phase = PH_COMMENT;
          end else begin
            // A lone slash opens a bare token; this byte then continues or ends it.
            r = begin_bare(r, CH_SLASH, limit);
            go_bare = !r.st.failed;
          end
        end
        PH_COMMENT: begin
          if (b == CH_LF) r.st.phase = PH_SKIP;
        end
        PH_BARE: go_bare = 1'b1;
        PH_QUOTED: begin
          if (b == CH_QUOTE) begin
            r = finish_token(r);
          end else if (b == CH_BSLASH) begin
            r.st.phase = PH_ESCAPE;
          end else begin
            r = ev_push(r, EV_BYTE, b, r.st.role);
          end
        end
        PH_ESCAPE: begin
          r = ev_push(r, EV_BYTE, (b == CH_N) ? CH_LF : ((b == CH_T) ? CH_TAB : b),
                      r.st.role);
          r.st.phase = PH_QUOTED;
        end
        PH_SKIP: go_skip = 1'b1;
        default: begin
          r.st.phase = PH_SKIP;
          go_skip = 1'b1;
        end
      endcase
      if (go_bare) begin
        if (ends_bare(b)) begin
          r = finish_token(r);
          go_skip = 1'b1;
        end else begin
          r = ev_push(r, EV_BYTE, b, r.st.role);
        end
      end
      if (go_skip) r = skip_byte(r, b, limit);
    end
    return r;
  endfunction

  // Parses the held partial byte-order mark as ordinary text.
  function automatic ctx_t replay(input ctx_t c, input logic [1:0] k,
                                  input logic [5:0] limit);
    ctx_t r;
    r = c;
    r.st.phase = PH_SKIP;
    r.st.held  = 2'd0;
    if (k >= 2'd1) r = feed(r, BOM0, limit);
    if (k >= 2'd2) r = feed(r, BOM1, limit);
    if (k == 2'd3) r = feed(r, BOM2, limit);
    return r;
  endfunction

  function automatic ctx_t finish_text(input ctx_t c, input logic [5:0] limit);
    ctx_t r;
    logic stop;
    r = c;
    stop = 1'b0;
    if (r.st.phase == PH_SLASH) begin
      r = begin_bare(r, CH_SLASH, limit);
      stop = r.st.failed;
    end
    if (!stop) begin
      if (r.st.phase == PH_BARE) r = finish_token(r);
      if ((r.st.phase == PH_QUOTED) || (r.st.phase == PH_ESCAPE)) begin
        r = fail(r);
      end else if (r.st.resume || (r.st.open_cnt != 6'd0)) begin
        r = fail(r);
      end else begin
        r = ev_push(r, EV_ACCEPT, 8'h00, 1'b0);
      end
    end
    return r;
  endfunction

  // Full step for one input byte: next state and the list of events it causes.
  function automatic ctx_t parse_step(input pst_t st, input logic [7:0] b,
                                      input logic last, input logic [5:0] limit);
    ctx_t c;
    c.st  = st;
    c.evl = '0;
    if (!c.st.failed) begin
      if (c.st.phase == PH_START) begin
        if ((c.st.held != 2'd3) && (b == mark_byte(c.st.held))) begin
          if (c.st.held == 2'd2) begin
            c.st.phase = PH_SKIP;
            c.st.held  = 2'd0;
          end else begin
            c.st.held = c.st.held + 2'd1;
          end
        end else begin
          c = replay(c, c.st.held, limit);
          c = feed(c, b, limit);
        end
      end else begin
        c = feed(c, b, limit);
      end
      if (last && !c.st.failed) begin
        if (c.st.phase == PH_START) c = replay(c, c.st.held, limit);
        if (!c.st.failed) c = finish_text(c, limit);
      end
    end
    if (last) c.st = PST_RESET;
    return c;
  endfunction

endpackage

### rtl/core/kvp_parse.sv
// Input register and parser state of the key-value text parser; one byte per step.
// Depends on kvp_pkg for the state type and the step function.
module kvp_parse import kvp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic [5:0] limit,
  input  logic       ld_ready,
  output logic       ld_valid,
  output evl_t       ld_list
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  pst_t       st_r;
  pst_t       st_nxt;
  ctx_t       step;
  logic       take;

  assign step      = parse_step(st_r, in_byte_r, in_last_r, limit);
  assign ld_valid  = in_vld_r;
  assign ld_list   = step.evl;
  assign take      = in_vld_r && ld_ready;
  assign in_tready = !in_vld_r || ld_ready;
  assign st_nxt    = take ? step.st : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= PST_RESET;
    end else begin
      st_r <= st_nxt;
      if (in_tvalid && in_tready) begin
        in_vld_r <= 1'b1;
      end else if (take) begin
        in_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

endmodule

### rtl/core/kvp_emit.sv
// Event list register of the key-value parser; sends one event per unstalled cycle.
// Depends on kvp_pkg for the event types.
module kvp_emit import kvp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ld_valid,
  input  evl_t        ld_list,
  output logic        ld_ready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [3:0]  out_tuser,
  output logic        out_tlast
);

  ev_t [MAX_EV-1:0]    list_r;
  logic [EV_CNT_W-1:0] cnt_r;
  logic [EV_CNT_W-1:0] ptr_r;
  ev_t                 cur;
  logic                last_ev;
  logic                sent;
  logic                load;

  assign cur        = list_r[ptr_r];
  assign out_tvalid = (ptr_r != cnt_r);
  assign last_ev    = ((ptr_r + EV_CNT_W'(1)) == cnt_r);
  assign sent       = out_tvalid && out_tready;
  assign ld_ready   = !out_tvalid || (sent && last_ev);
  assign load       = ld_valid && ld_ready;

  assign out_tdata = {2'b00, cur.level, cur.data};
  assign out_tuser = {cur.role, cur.kind};
  assign out_tlast = last_ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
    end else if (load) begin
      cnt_r <= ld_list.cnt;
      ptr_r <= '0;
    end else if (sent) begin
      ptr_r <= ptr_r + EV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) list_r <= ld_list.ev;
  end

endmodule

### rtl/core/keyvalue_text_stream_parser_core.sv
// Key-value text stream parser, top level. A byte accepted into the input register has
// its events computed with the parser state and loaded into the event register, which
// drives the output. Throughput: one byte per cycle while each byte makes at most one
// event and out_tready is high; a byte with more events sends them one per cycle.
// Reset (rst_n low, synchronous) returns the parser to the start of a text, drops
// pending events and sets nesting_limit back to 32.
module keyvalue_text_stream_parser_core import kvp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel, one text byte per transaction.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] text_byte
  input  logic        in_tlast,    // end_of_text
  // Result channel, one event per transaction.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] byte_out, [13:8] nesting_level, [15:14] zero
  output logic [3:0]  out_tuser,   // [2:0] event_kind, [3] token_role
  output logic        out_tlast,   // last_of_run
  // Configuration: nesting_limit.
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data
);

  // The user must write the nesting limit only while the parser is idle (not enforced
  // here), so no shadow copy; values over the built-in maximum clamp in the step logic.
  logic [5:0] nesting_limit_r;
  logic       ld_valid;
  logic       ld_ready;
  evl_t       ld_list;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nesting_limit_r <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      nesting_limit_r <= cfg_wr_data;
    end
  end

  // The parse stage holds one accepted byte and the parser state. Its events for that
  // byte are computed in one pass and move into the event register as soon as the
  // previous byte's last event leaves, so the next byte can already be waiting.
  kvp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .limit     (nesting_limit_r),
    .ld_ready  (ld_ready),
    .ld_valid  (ld_valid),
    .ld_list   (ld_list)
  );

  // The emit stage walks the event list; a byte that makes no event passes through
  // without showing anything on the output.
  kvp_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_valid   (ld_valid),
    .ld_list    (ld_list),
    .ld_ready   (ld_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
